[design/assert_macros.svh]
// assertion helpers used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[design/frh_pkg.sv]
package frh_pkg;

   // fnv-1a 64-bit constants
   localparam logic [63:0] FnvBasis = 64'd14695981039346656037;

   // token kinds as they arrive on the request channel
   typedef enum logic [2:0] {
      FN_START    = 3'd0,
      FN_BYTE     = 3'd1,
      FN_WORD     = 3'd2,
      FN_LOADED   = 3'd3,
      FN_UNLOADED = 3'd4,
      FN_RUN      = 3'd5
   } frh_func_type;

   // marker bytes folded ahead of tagged tokens
   typedef enum logic [1:0] {
      MK_UNMAPPED = 2'd0,
      MK_UNLOADED = 2'd1,
      MK_LOADED   = 2'd2
   } frh_mark_type;

   // classified command passed from the front end to the back end
   typedef struct packed {
      logic         start;
      logic         last;
      logic         mark_en;
      frh_mark_type mark;
      logic [3:0]   data_len;
      logic [63:0]  data;
   } frh_cmd_type;

   // queue status towards both sides
   typedef struct packed {
      logic full;
      logic empty;
   } frh_qstat_type;

   // back end status
   typedef struct packed {
      logic pop;
      logic emit;
   } frh_bstat_type;

   // back end sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MARK,
      ST_DATA,
      ST_EMIT
   } frh_state_type;

   // one fnv-1a byte step; prime is 2^40 + 0x1b3, built from shifts and adds
   function automatic logic [63:0] frh_fold(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] x;
      x = h ^ {56'd0, b};
      return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

endpackage

[design/frh_front.sv]
module frh_front
   import frh_pkg::*;
(
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [2:0]    req_func,
   input  logic [63:0]   req_value,
   input  logic          req_last,
   input  frh_qstat_type q_stat,
   output logic          q_push,
   output frh_cmd_type   q_cmd
);

   // take a request whenever the queue has room
   assign req_ready = !q_stat.full;
   assign q_push    = req_valid && !q_stat.full;

   // classify the token into marker and byte run
   always_comb begin
      q_cmd          = '0;
      q_cmd.last     = req_last;
      q_cmd.mark     = MK_UNMAPPED;
      unique case (req_func)
         FN_START: begin
            q_cmd.start = 1'b1;
         end
         FN_BYTE: begin
            q_cmd.data_len = 4'd1;
            q_cmd.data     = {56'd0, req_value[7:0]};
         end
         FN_WORD: begin
            q_cmd.data_len = 4'd8;
            q_cmd.data     = req_value;
         end
         FN_LOADED: begin
            q_cmd.mark_en  = 1'b1;
            q_cmd.mark     = MK_LOADED;
            q_cmd.data_len = 4'd1;
            q_cmd.data     = {56'd0, req_value[7:0]};
         end
         FN_UNLOADED: begin
            q_cmd.mark_en  = 1'b1;
            q_cmd.mark     = MK_UNLOADED;
         end
         FN_RUN: begin
            q_cmd.mark_en  = 1'b1;
            q_cmd.mark     = MK_UNMAPPED;
            q_cmd.data_len = 4'd8;
            q_cmd.data     = req_value;
         end
         // undefined kinds leave the hash alone
         default: begin
            q_cmd.data_len = 4'd0;
         end
      endcase
   end

endmodule

[design/frh_queue.sv]
module frh_queue
   import frh_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  frh_cmd_type   push_cmd,
   input  logic          pop,
   output frh_cmd_type   head_cmd,
   output frh_qstat_type stat
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   frh_cmd_type        entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[design/frh_back.sv]
module frh_back
   import frh_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  frh_cmd_type   head_cmd,
   input  frh_qstat_type q_stat,
   output frh_bstat_type stat,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [63:0]   rsp_digest
);

   frh_state_type state_ff, state_in;
   logic [63:0]   hash_ff, hash_in;
   logic [63:0]   data_ff, data_in;
   logic [3:0]    cnt_ff, cnt_in;
   frh_mark_type  mark_ff, mark_in;
   logic          last_ff, last_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [63:0]   rsp_digest_ff, rsp_digest_in;
   logic          out_free;
   logic [63:0]   hash_start;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_digest = rsp_digest_ff;
   assign hash_start = head_cmd.start ? FnvBasis : hash_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               priority if (head_cmd.mark_en) state_in = ST_MARK;
               else if (head_cmd.data_len != '0) state_in = ST_DATA;
               else if (head_cmd.last) state_in = ST_EMIT;
               else state_in = ST_IDLE;
            end
         end
         ST_MARK: begin
            priority if (cnt_ff != '0) state_in = ST_DATA;
            else if (last_ff) state_in = ST_EMIT;
            else state_in = ST_IDLE;
         end
         ST_DATA: begin
            if (cnt_ff == 4'd1) begin
               state_in = last_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and handshake outputs
   always_comb begin
      stat.pop      = 1'b0;
      stat.emit     = 1'b0;
      hash_in       = hash_ff;
      data_in       = data_ff;
      cnt_in        = cnt_ff;
      mark_in       = mark_ff;
      last_in       = last_ff;
      rsp_digest_in = rsp_digest_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            // load the next command; a start token reloads the basis here
            if (!q_stat.empty) begin
               stat.pop = 1'b1;
               hash_in  = hash_start;
               data_in  = head_cmd.data;
               cnt_in   = head_cmd.data_len;
               mark_in  = head_cmd.mark;
               last_in  = head_cmd.last;
            end
         end
         ST_MARK: begin
            hash_in = frh_fold(hash_ff, {6'd0, mark_ff});
         end
         ST_DATA: begin
            // one byte per cycle, least significant first
            hash_in = frh_fold(hash_ff, data_ff[7:0]);
            data_in = data_ff >> 8;
            cnt_in  = cnt_ff - 1'b1;
         end
         ST_EMIT: begin
            if (out_free) begin
               stat.emit     = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_digest_in = hash_ff;
            end
         end
         default: begin
            stat.pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hash_ff      <= FnvBasis;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working payload registers
   always_ff @(posedge clock) begin
      data_ff       <= data_in;
      cnt_ff        <= cnt_in;
      mark_ff       <= mark_in;
      last_ff       <= last_in;
      rsp_digest_ff <= rsp_digest_in;
   end

endmodule

[design/fnv1a64_record_hasher_top.sv]
// fnv-1a 64-bit record hasher
// requests carry a token: func (kind), value (a byte or a 64-bit word of data)
// and last. start reloads the offset basis; other kinds fold any marker
// byte and data bytes into the running hash, one byte per cycle.
// a request with last set yields one response, rsp_digest, the hash after
// that token; other requests yield none.
// a request enters a small command queue on the edge it is taken, so
// req_ready only drops when the queue is full.
// the back end loads a command from the queue, folds its marker byte if
// it has one, then folds its data bytes: start and unloaded tokens have
// no data bytes, byte and loaded tokens one, word and unmapped run eight.
// a response takes a further emit state after the last fold: rsp_valid and
// rsp_digest are registered from that state once the output is free.
// the fold sequencer in the back end sets the sustained rate.
// reset empties the queue, drops any pending response and loads the
// offset basis into the hash.
// if rsp_ready stays low the held response waits; the back end stalls at
// the next response and the queue then fills and drops req_ready.
`include "assert_macros.svh"

module fnv1a64_record_hasher_top
   import frh_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [63:0] req_value,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_digest
);

   frh_qstat_type q_stat;
   frh_bstat_type b_stat;
   frh_cmd_type   push_cmd;
   frh_cmd_type   head_cmd;
   logic          q_push;

   // request decode
   frh_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .req_value (req_value),
      .req_last  (req_last),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_cmd     (push_cmd)
   );

   // command queue
   frh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (b_stat.pop),
      .head_cmd (head_cmd),
      .stat     (q_stat)
   );

   // fold sequencer and response register
   frh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .q_stat     (q_stat),
      .stat       (b_stat),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_digest (rsp_digest)
   );

   // checks
   `ASSERT_CLK(a_pop_not_empty, clock, reset, !b_stat.pop || !q_stat.empty)
   `ASSERT_CLK(a_push_not_full, clock, reset, !q_push || !q_stat.full)
   `ASSERT_NEXT(a_emit_shows, clock, reset, b_stat.emit, rsp_valid)
   `ASSERT_CLK(a_rsp_from_emit, clock, reset, !$rose(rsp_valid) || $past(b_stat.emit))

endmodule
